>>> design/cvw_pkg.sv
// Shared constants and types for the valid-window 2D convolution block.
package cvw_pkg;

   localparam int KERNEL_SIZE  = 3;
   localparam int IMAGE_WIDTH  = 64;
   localparam int IMAGE_HEIGHT = 64;

   localparam int KERNEL_TAPS = KERNEL_SIZE * KERNEL_SIZE;
   localparam int LINE_ROWS   = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;

   localparam int DATA_W    = 16;
   localparam int INDEX_W   = 4;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ROW_SUM_W = PROD_W + $clog2(KERNEL_SIZE + 1);
   localparam int CONV_W    = 40;
   localparam int POS_W     = 6;
   localparam int LINE_W    = DATA_W * LINE_ROWS;
   localparam int COL_W     = $clog2(IMAGE_WIDTH);
   localparam int ROW_W     = $clog2(IMAGE_HEIGHT);

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_PIXEL = 1'b1
   } command_type;

endpackage

>>> design/cvw_if.sv
// Request and response channel interfaces of the convolution block.
interface cvw_req_if;
   import cvw_pkg::*;

   logic                     valid;
   logic                     ready;
   command_type              command;
   logic [INDEX_W-1:0]       coeff_index;
   logic signed [DATA_W-1:0] coeff_value;
   logic signed [DATA_W-1:0] pixel;

   modport source (output valid, command, coeff_index, coeff_value, pixel, input ready);
   modport sink   (input valid, command, coeff_index, coeff_value, pixel, output ready);
endinterface

interface cvw_rsp_if;
   import cvw_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [CONV_W-1:0] conv_value;
   logic [POS_W-1:0]         out_row;
   logic [POS_W-1:0]         out_col;
   logic                     frame_last;

   modport source (output valid, conv_value, out_row, out_col, frame_last, input ready);
   modport sink   (input valid, conv_value, out_row, out_col, frame_last, output ready);
endinterface

>>> design/conv2d_valid_window.sv
// A pixel accepted into stage A moves through stages B and C into the result register.
// Throughput: one item (load or pixel) per cycle unless rsp.ready stalls the chain;
// the line RAM is read ahead at the column counter, so a pixel never waits on its read port.
// Reset clears counters, stage valid bits and the kernel; line RAM and window hold
// stale data that only the first KERNEL_SIZE-1 rows of a frame see, which emit nothing.
module conv2d_valid_window import cvw_pkg::*; (
   input logic   clock,
   input logic   reset,
   cvw_req_if.sink   req,
   cvw_rsp_if.source rsp
);

   // position of the next pixel
   logic [COL_W-1:0] col_count_ff;
   logic [ROW_W-1:0] row_count_ff;

   // stage A: accepted item plus line RAM data for its column
   logic                     a_valid_ff;
   command_type              a_command_ff;
   logic [INDEX_W-1:0]       a_index_ff;
   logic signed [DATA_W-1:0] a_coeff_ff;
   logic signed [DATA_W-1:0] a_pixel_ff;
   logic [COL_W-1:0]         a_col_ff;
   logic [ROW_W-1:0]         a_row_ff;

   logic signed [DATA_W-1:0] kernel_ff [KERNEL_TAPS];
   logic signed [DATA_W-1:0] window_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [DATA_W-1:0] window_in [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [DATA_W-1:0] column    [KERNEL_SIZE];

   // stage B: products
   logic                     b_valid_ff;
   logic signed [PROD_W-1:0] b_prod_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [PROD_W-1:0] b_prod_in [KERNEL_SIZE][KERNEL_SIZE];
   logic [POS_W-1:0]         b_row_ff;
   logic [POS_W-1:0]         b_col_ff;
   logic                     b_last_ff;

   // stage C: kernel row sums
   logic                        c_valid_ff;
   logic signed [ROW_SUM_W-1:0] c_sum_ff [KERNEL_SIZE];
   logic signed [ROW_SUM_W-1:0] c_sum_in [KERNEL_SIZE];
   logic [POS_W-1:0]            c_row_ff;
   logic [POS_W-1:0]            c_col_ff;
   logic                        c_last_ff;

   // result register
   logic                     out_valid_ff;
   logic signed [CONV_W-1:0] out_conv_ff;
   logic signed [CONV_W-1:0] out_conv_in;
   logic [POS_W-1:0]         out_row_ff;
   logic [POS_W-1:0]         out_col_ff;
   logic                     out_last_ff;

   logic req_fire;
   logic a_fire;
   logic a_ready;
   logic b_ready;
   logic c_ready;
   logic out_ready;
   logic a_is_pixel;
   logic a_emit;
   logic a_last;
   logic [31:0] a_row_off;
   logic [31:0] a_col_off;

   logic [LINE_W-1:0] line_rd;
   logic [LINE_W-1:0] line_wr;

   // handshake chain: each stage frees when its item moves on
   assign out_ready = !out_valid_ff || rsp.ready;
   assign c_ready   = !c_valid_ff || out_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_fire    = a_valid_ff && b_ready;
   assign a_ready   = !a_valid_ff || a_fire;
   assign req.ready = a_ready;
   assign req_fire  = req.valid && a_ready;

   assign a_is_pixel = (a_command_ff == CMD_PIXEL);
   assign a_emit     = a_is_pixel && (a_row_ff >= ROW_W'(KERNEL_SIZE - 1))
                       && (a_col_ff >= COL_W'(KERNEL_SIZE - 1));
   assign a_last     = (a_row_ff == ROW_W'(IMAGE_HEIGHT - 1))
                       && (a_col_ff == COL_W'(IMAGE_WIDTH - 1));
   assign a_row_off  = 32'(a_row_ff) - 32'(KERNEL_SIZE - 1);
   assign a_col_off  = 32'(a_col_ff) - 32'(KERNEL_SIZE - 1);

   cvw_ram #(
      .WIDTH (LINE_W),
      .DEPTH (IMAGE_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (a_fire && a_is_pixel),
      .wr_addr (a_col_ff),
      .wr_data (line_wr),
      .rd_en   (req_fire),
      .rd_addr (col_count_ff),
      .rd_data (line_rd)
   );

   // new window column, line shift and products
   always_comb begin
      line_wr = line_rd;
      for (int k = 0; k < LINE_ROWS - 1; k++) begin
         line_wr[k*DATA_W +: DATA_W] = line_rd[(k+1)*DATA_W +: DATA_W];
      end
      line_wr[(LINE_ROWS-1)*DATA_W +: DATA_W] = a_pixel_ff;

      for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
         column[k] = line_rd[k*DATA_W +: DATA_W];
      end
      column[KERNEL_SIZE-1] = a_pixel_ff;

      for (int m = 0; m < KERNEL_SIZE; m++) begin
         for (int n = 0; n < KERNEL_SIZE - 1; n++) begin
            window_in[m][n] = window_ff[m][n+1];
         end
         window_in[m][KERNEL_SIZE-1] = column[m];
      end

      // flipped kernel
      for (int m = 0; m < KERNEL_SIZE; m++) begin
         for (int n = 0; n < KERNEL_SIZE; n++) begin
            b_prod_in[m][n] = window_in[m][n]
               * kernel_ff[(KERNEL_SIZE-1-m)*KERNEL_SIZE + (KERNEL_SIZE-1-n)];
         end
      end
   end

   always_comb begin
      for (int m = 0; m < KERNEL_SIZE; m++) begin
         c_sum_in[m] = '0;
         for (int n = 0; n < KERNEL_SIZE; n++) begin
            c_sum_in[m] = c_sum_in[m] + ROW_SUM_W'(b_prod_ff[m][n]);
         end
      end
      out_conv_in = '0;
      for (int m = 0; m < KERNEL_SIZE; m++) begin
         out_conv_in = out_conv_in + CONV_W'(c_sum_ff[m]);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int t = 0; t < KERNEL_TAPS; t++) begin
            kernel_ff[t] <= '0;
         end
      end else begin
         if (req_fire && req.command == CMD_PIXEL) begin
            if (col_count_ff == COL_W'(IMAGE_WIDTH - 1)) begin
               col_count_ff <= '0;
               if (row_count_ff == ROW_W'(IMAGE_HEIGHT - 1)) begin
                  row_count_ff <= '0;
               end else begin
                  row_count_ff <= row_count_ff + 1'b1;
               end
            end else begin
               col_count_ff <= col_count_ff + 1'b1;
            end
         end
         if (a_ready) begin
            a_valid_ff <= req.valid;
         end
         // out-of-range indexes match no tap and are dropped
         if (a_fire && !a_is_pixel) begin
            for (int t = 0; t < KERNEL_TAPS; t++) begin
               if (a_index_ff == INDEX_W'(t)) begin
                  kernel_ff[t] <= a_coeff_ff;
               end
            end
         end
         if (b_ready) begin
            b_valid_ff <= a_fire && a_emit;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= c_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_command_ff <= req.command;
         a_index_ff   <= req.coeff_index;
         a_coeff_ff   <= req.coeff_value;
         a_pixel_ff   <= req.pixel;
         a_col_ff     <= col_count_ff;
         a_row_ff     <= row_count_ff;
      end
      if (a_fire && a_is_pixel) begin
         window_ff <= window_in;
      end
      if (b_ready) begin
         b_prod_ff <= b_prod_in;
         b_row_ff  <= a_row_off[POS_W-1:0];
         b_col_ff  <= a_col_off[POS_W-1:0];
         b_last_ff <= a_last;
      end
      if (c_ready) begin
         c_sum_ff  <= c_sum_in;
         c_row_ff  <= b_row_ff;
         c_col_ff  <= b_col_ff;
         c_last_ff <= b_last_ff;
      end
      if (out_ready) begin
         out_conv_ff <= out_conv_in;
         out_row_ff  <= c_row_ff;
         out_col_ff  <= c_col_ff;
         out_last_ff <= c_last_ff;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.conv_value = out_conv_ff;
   assign rsp.out_row    = out_row_ff;
   assign rsp.out_col    = out_col_ff;
   assign rsp.frame_last = out_last_ff;

endmodule

>>> design/cvw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cvw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/cvw_checker.sv
// Port-level checks for the convolution block, bound to its top level.
module cvw_checker import cvw_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [CONV_W-1:0] rsp_conv_value,
   input logic [POS_W-1:0]         rsp_out_row,
   input logic [POS_W-1:0]         rsp_out_col,
   input logic                     rsp_frame_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_conv_value)
         && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_frame_last))
      else $error("stalled result changed");

   // the frame's final result sits at the bottom-right of the valid image
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |->
         rsp_out_row == POS_W'(IMAGE_HEIGHT - KERNEL_SIZE)
         && rsp_out_col == POS_W'(IMAGE_WIDTH - KERNEL_SIZE))
      else $error("frame_last at wrong position");

   // an empty result register leaves the whole pipeline free to take an item
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // track accepts so a response only follows a request
   logic seen_req_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_req_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         seen_req_ff <= 1'b1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_req_ff)
      else $error("result without any accepted item");

endmodule

bind conv2d_valid_window cvw_checker u_cvw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_conv_value (rsp.conv_value),
   .rsp_out_row    (rsp.out_row),
   .rsp_out_col    (rsp.out_col),
   .rsp_frame_last (rsp.frame_last)
);

>>> tb/tb.sv
// Self-checking testbench for the streaming 3x3 valid-window convolution block.
`timescale 1ns / 100ps

module tb;
   import cvw_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int HOLD_START   = 800;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 8;
   localparam int FILL_PIXELS  = 2 * IMAGE_WIDTH + KERNEL_SIZE;

   typedef logic signed [DATA_W-1:0] sample_type;

   typedef struct {
      command_type        command;
      logic [INDEX_W-1:0] coeff_index;
      sample_type         coeff_value;
      sample_type         pixel;
   } conv_item_type;

   typedef struct {
      logic signed [CONV_W-1:0] conv_value;
      logic [POS_W-1:0]         out_row;
      logic [POS_W-1:0]         out_col;
      logic                     frame_last;
   } conv_result_type;

   // One row of the directed table: value goes to the coefficient or the pixel,
   // loads with a count step through consecutive indexes.
   typedef struct {
      command_type     command;
      int              index;
      int              value;
      int              count;
      bit              known;
      conv_result_type result;
   } stim_row_type;

   typedef struct {
      int              item_no;
      conv_result_type result;
   } known_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cvw_req_if req_ch ();
   cvw_rsp_if rsp_ch ();

   conv2d_valid_window u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Own copy of the block state
   sample_type line_mem [LINE_ROWS][IMAGE_WIDTH];
   sample_type window   [KERNEL_SIZE][KERNEL_SIZE];
   sample_type kernel   [KERNEL_TAPS];
   int         row_pos;
   int         col_pos;

   conv_result_type  expected_results[$];
   known_result_type known_results[$];
   stim_row_type     stim_rows[$];

   int items_sent      = 0;
   int pixels_sent     = 0;
   int items_accepted  = 0;
   int results_checked = 0;
   int frames_seen     = 0;
   int error_count     = 0;
   int burst_left      = 0;
   int idle_cycles     = 0;

   function automatic void clear_conv_state();
      foreach (line_mem[r, c]) line_mem[r][c] = '0;
      foreach (window[m, n]) window[m][n] = '0;
      foreach (kernel[t]) kernel[t] = '0;
      row_pos = 0;
      col_pos = 0;
   endfunction

   // Shift one pixel through line store and window; return 1 when a result is due.
   function automatic bit convolve_pixel(input sample_type px, output conv_result_type res);
      sample_type column [KERNEL_SIZE];
      longint     acc;
      bit         emit;
      acc = 0;
      for (int k = 0; k < KERNEL_SIZE - 1; k++) column[k] = line_mem[k][col_pos];
      column[KERNEL_SIZE-1] = px;
      for (int k = 0; k + 1 < KERNEL_SIZE - 1; k++) line_mem[k][col_pos] = line_mem[k+1][col_pos];
      line_mem[KERNEL_SIZE-2][col_pos] = px;
      for (int m = 0; m < KERNEL_SIZE; m++) begin
         for (int n = 0; n + 1 < KERNEL_SIZE; n++) window[m][n] = window[m][n+1];
         window[m][KERNEL_SIZE-1] = column[m];
      end
      emit = (row_pos >= KERNEL_SIZE - 1) && (col_pos >= KERNEL_SIZE - 1);
      res.conv_value = '0;
      res.out_row    = '0;
      res.out_col    = '0;
      res.frame_last = 1'b0;
      if (emit) begin
         // flipped kernel: true convolution
         for (int m = 0; m < KERNEL_SIZE; m++)
            for (int n = 0; n < KERNEL_SIZE; n++)
               acc += longint'(window[m][n]) *
                      longint'(kernel[(KERNEL_SIZE-1-m)*KERNEL_SIZE + (KERNEL_SIZE-1-n)]);
         res.conv_value = acc[CONV_W-1:0];
         res.out_row    = POS_W'(row_pos - (KERNEL_SIZE - 1));
         res.out_col    = POS_W'(col_pos - (KERNEL_SIZE - 1));
         res.frame_last = (row_pos == IMAGE_HEIGHT - 1) && (col_pos == IMAGE_WIDTH - 1);
      end
      if (col_pos + 1 >= IMAGE_WIDTH) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= IMAGE_HEIGHT) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return emit;
   endfunction

   function automatic void check_field(input string name, input logic signed [CONV_W-1:0] want,
                                       input logic signed [CONV_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Monitor: compare results, then predict from the accepted item.
   always @(posedge clock) begin
      conv_result_type predicted;
      conv_result_type want;
      bit              emit;
      if (reset) begin
         clear_conv_state();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: conv_value %0d, row %0d, col %0d",
                      rsp_ch.conv_value, rsp_ch.out_row, rsp_ch.out_col);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("conv_value", want.conv_value, rsp_ch.conv_value);
               check_field("out_row", want.out_row, rsp_ch.out_row);
               check_field("out_col", want.out_col, rsp_ch.out_col);
               check_field("frame_last", want.frame_last, rsp_ch.frame_last);
               results_checked++;
               if (rsp_ch.frame_last === 1'b1) frames_seen++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            emit = 1'b0;
            if (req_ch.command == CMD_LOAD) begin
               // drop loads beyond the last tap
               if (req_ch.coeff_index < KERNEL_TAPS)
                  kernel[int'(req_ch.coeff_index)] = req_ch.coeff_value;
            end else begin
               emit = convolve_pixel(req_ch.pixel, predicted);
            end
            if (known_results.size() != 0 && known_results[0].item_no == items_accepted) begin
               if (emit) predicted = known_results[0].result;
               known_results.delete(0);
            end
            if (emit) expected_results.push_back(predicted);
            items_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, expected_results.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic sample_type pick_sample();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 6) return sample_type'(-32768);
      if (roll < 12) return sample_type'(32767);
      if (roll < 16) return '0;
      return DATA_W'($urandom);
   endfunction

   function automatic conv_item_type random_item();
      conv_item_type item;
      item.coeff_index = INDEX_W'($urandom);
      item.coeff_value = pick_sample();
      item.pixel       = pick_sample();
      if ($urandom_range(0, 99) < 8) begin
         item.command = CMD_LOAD;
         // mostly valid taps, the rest takes any index and may land beyond the kernel
         if ($urandom_range(0, 99) < 85)
            item.coeff_index = INDEX_W'($urandom_range(0, KERNEL_TAPS - 1));
      end else begin
         item.command = CMD_PIXEL;
      end
      return item;
   endfunction

   task automatic send_item(input conv_item_type item, input int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= item.command;
      req_ch.coeff_index <= item.coeff_index;
      req_ch.coeff_value <= item.coeff_value;
      req_ch.pixel       <= item.pixel;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      if (item.command == CMD_PIXEL) pixels_sent++;
   endtask

   task automatic add_row(input command_type command, input int index, input int value,
                          input int count, input bit known = 1'b0, input longint conv = 0,
                          input int out_row = 0, input int out_col = 0);
      stim_row_type row;
      row.command           = command;
      row.index             = index;
      row.value             = value;
      row.count             = count;
      row.known             = known;
      row.result.conv_value = conv[CONV_W-1:0];
      row.result.out_row    = POS_W'(out_row);
      row.result.out_col    = POS_W'(out_col);
      row.result.frame_last = 1'b0;
      stim_rows.push_back(row);
   endtask

   // Sender
   initial begin
      conv_item_type    item;
      known_result_type known;
      int               random_count;
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_LOAD;
      req_ch.coeff_index <= '0;
      req_ch.coeff_value <= '0;
      req_ch.pixel       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // kernel is zero after reset, so the first window sums to zero
      add_row(CMD_PIXEL, 0, 32767, FILL_PIXELS, 1'b1, 0, 0, 0);
      add_row(CMD_LOAD, 0, -32768, KERNEL_TAPS);
      add_row(CMD_LOAD, KERNEL_TAPS, 32767, 1);
      add_row(CMD_LOAD, (1 << INDEX_W) - 1, -1, 1);
      add_row(CMD_PIXEL, 0, -32768, FILL_PIXELS, 1'b1, 64'sd9663676416, 2, 3);
      add_row(CMD_PIXEL, 0, 32767, FILL_PIXELS, 1'b1, -64'sd9663381504, 4, 6);
      add_row(CMD_LOAD, 0, 32767, KERNEL_TAPS);
      add_row(CMD_PIXEL, 0, 32767, 1, 1'b1, 64'sd9663086601, 4, 7);
      add_row(CMD_LOAD, 4, 0, 1);
      add_row(CMD_PIXEL, 0, 0, 1);
      add_row(CMD_LOAD, 8, 21845, 1);
      add_row(CMD_PIXEL, 0, -21846, 1);
      add_row(CMD_PIXEL, 0, 21845, 1);
      add_row(CMD_LOAD, 2, -21846, 1);
      add_row(CMD_PIXEL, 0, -1, 2);

      foreach (stim_rows[r]) begin
         for (int i = 0; i < stim_rows[r].count; i++) begin
            item = random_item();
            item.command = stim_rows[r].command;
            if (item.command == CMD_LOAD) begin
               item.coeff_index = INDEX_W'(stim_rows[r].index + i);
               item.coeff_value = DATA_W'(stim_rows[r].value);
            end else begin
               item.pixel = DATA_W'(stim_rows[r].value);
            end
            if (stim_rows[r].known && i == stim_rows[r].count - 1) begin
               known.item_no = items_sent;
               known.result  = stim_rows[r].result;
               known_results.push_back(known);
            end
            send_item(item, pick_gap());
         end
      end

      // random mix of loads and pixels
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         send_item(random_item(), pick_gap());
         random_count++;
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d pixels) with random gaps, stalls and a long hold-off;",
               items_sent, pixels_sent);
      $display("%0d results checked, %0d frame-last flags seen, %0d mismatches",
               results_checked, frames_seen, error_count);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Receiver: random stalls, long ready stretches, one long hold-off
   initial begin
      int  span;
      int  roll;
      bit  held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         roll = $urandom_range(0, 99);
         if (!held && items_sent >= HOLD_START) begin
            held = 1'b1;
            span = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (roll < 10) begin
            span = $urandom_range(100, 300);
            rsp_ch.ready <= 1'b1;
         end else if (roll < 55) begin
            span = $urandom_range(1, 30);
            rsp_ch.ready <= 1'b1;
         end else if (roll < 93) begin
            span = $urandom_range(1, 3);
            rsp_ch.ready <= 1'b0;
         end else begin
            span = $urandom_range(15, 60);
            rsp_ch.ready <= 1'b0;
         end
         repeat (span) @(posedge clock);
      end
   end

endmodule

>>> sim.f
design/cvw_pkg.sv
design/cvw_if.sv
design/cvw_ram.sv
design/conv2d_valid_window.sv
design/cvw_checker.sv
tb/tb.sv
